@@ rtl/evg_pkg.sv @@
// Package for the Erlang variate generator: widths, logarithm constants and shared types.
package evg_pkg;

  // Field and state widths
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SHAPE_W   = 7;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned SUM_W     = 39;
  localparam int unsigned VAR_W     = 36;
  localparam int unsigned TERM_W    = 33;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned PROD_W    = SUM_W + SCALE_W;
  localparam int unsigned SUM_FRAC  = 27;
  localparam int unsigned MAX_SHAPE = 64;

  // Logarithm datapath: unsigned Q.58, one fraction bit resolved per step
  localparam int unsigned FRAC_BITS = 58;
  localparam int unsigned X_W       = FRAC_BITS + 1;
  localparam int unsigned LOG_STEPS = 32;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned TAB_IDX_W = 6;
  localparam int unsigned NORM_LAST = 4;
  localparam int unsigned MUL_SPLIT = 20;

  localparam logic [ACC_W-1:0] ONE_Q   = 64'd1 << FRAC_BITS;
  localparam logic [ACC_W-1:0] ROUND_Q = 64'd1 << (FRAC_BITS - 28);

  typedef logic [FRAC_BITS-1:0] step_log_t [LOG_STEPS+1];

  // ln 2 in Q.58 from truncated series terms
  function automatic logic [ACC_W-1:0] calc_ln2();
    logic [ACC_W-1:0] acc;
    acc = '0;
    for (int n = 1; n <= FRAC_BITS; n++) begin
      acc = acc + (ONE_Q >> n) / ACC_W'(n);
    end
    return acc;
  endfunction

  // ln(1 + 2^-i) in Q.58 from truncated alternating series terms
  function automatic step_log_t build_step_log();
    step_log_t        tab;
    logic [ACC_W-1:0] acc;
    for (int i = 0; i <= LOG_STEPS; i++) begin
      acc = '0;
      if (i > 0) begin
        for (int n = 1; n * i <= FRAC_BITS; n++) begin
          if ((n % 2) == 1) begin
            acc = acc + (ONE_Q >> (n * i)) / ACC_W'(n);
          end else begin
            acc = acc - (ONE_Q >> (n * i)) / ACC_W'(n);
          end
        end
      end
      tab[i] = acc[FRAC_BITS-1:0];
    end
    return tab;
  endfunction

  localparam logic [ACC_W-1:0] LN2_Q     = calc_ln2();
  localparam step_log_t        STEP_LOG  = build_step_log();
  localparam logic [ACC_W-1:0] LN2_X16_Q = LN2_Q * 64'd16;
  localparam logic [ACC_W-1:0] LN2_X8_Q  = LN2_Q * 64'd8;
  localparam logic [ACC_W-1:0] LN2_X4_Q  = LN2_Q * 64'd4;
  localparam logic [ACC_W-1:0] LN2_X2_Q  = LN2_Q * 64'd2;

  // Configuration register indexes
  localparam logic REG_SHAPE = 1'b0;
  localparam logic REG_SCALE = 1'b1;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              norm;
    logic              iter;
    logic              fin;
    logic              sum;
    logic              mul_lo;
    logic              mul_hi;
    logic              out_load;
    logic [STEP_W-1:0] idx;
  } evg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic word_zero;
    logic emit;
  } evg_sts_t;

endpackage

@@ rtl/evg_if.sv @@
// Valid/ready channel interfaces for uniform input words and variate output words.
interface evg_in_if;
  logic                        valid;
  logic                        ready;
  logic [evg_pkg::WORD_W-1:0]  uniform_word;

  modport source (output valid, output uniform_word, input ready);
  modport sink   (input valid, input uniform_word, output ready);
endinterface

interface evg_out_if;
  logic                        valid;
  logic                        ready;
  logic [evg_pkg::VAR_W-1:0]   variate_value;

  modport source (output valid, output variate_value, input ready);
  modport sink   (input valid, input variate_value, output ready);
endinterface

@@ rtl/erlang_variate_generator_core.sv @@
// Top level of the Erlang variate generator: configuration registers, controller and datapath.
//
// Usage:
//   in_i carries one 32-bit uniform word per handshake (u = word / 2^32). A zero
//   word is taken and dropped with no effect on the sum.
//   Every other word adds -ln(u) (Q.27) to a running sum. On the shape-th word
//   the block sends scale * sum (16 fraction bits) on out_o and clears the sum.
//   APB registers: 0x0 shape_count (7 bits, reset 1), 0x4 scale_value (Q8.16,
//   reset 1.0). Write them only while the block is idle.
// Timing:
//   One word is in work at a time. A nonzero word passes the accept cycle,
//   5 normalise steps, 32 shift-add logarithm steps (one fraction bit per step),
//   finish and sum before the next word can be taken.
//   A word that completes a variate adds the two multiply halves and the output
//   load, which waits while the previous result is still pending.
// Reset clears the sum, the count and the output valid; registers go to reset
// values. A stalled receiver holds the result in the output register; the block
// keeps taking words and only waits at the output load of the next variate.
module erlang_variate_generator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  evg_in_if.sink                        in_i,
  evg_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [evg_pkg::PADDR_W-1:0]   paddr,
  input  logic [evg_pkg::PDATA_W-1:0]   pwdata,
  output logic [evg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import evg_pkg::*;

  logic [SHAPE_W-1:0] shape_q;
  logic [SCALE_W-1:0] scale_q;
  logic               reg_sel;
  logic               cfg_wr;
  evg_cmd_t           cmd;
  evg_sts_t           sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHAPE_W'(1);
      scale_q <= SCALE_W'(65536);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SHAPE: shape_q <= pwdata[SHAPE_W-1:0];
        REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
        default:   shape_q <= shape_q;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_sel)
      REG_SHAPE: prdata = PDATA_W'(shape_q);
      REG_SCALE: prdata = PDATA_W'(scale_q);
      default:   prdata = '0;
    endcase
  end

  evg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  evg_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .word_i    (in_i.uniform_word),
    .shape_i   (shape_q),
    .scale_i   (scale_q),
    .variate_o (out_o.variate_value)
  );

endmodule

@@ rtl/evg_datapath.sv @@
// Datapath: normaliser, shift-add logarithm, running sum, split scale multiply, output register.
module evg_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  evg_pkg::evg_cmd_t             cmd_i,
  output evg_pkg::evg_sts_t             sts_o,
  input  logic [evg_pkg::WORD_W-1:0]    word_i,
  input  logic [evg_pkg::SHAPE_W-1:0]   shape_i,
  input  logic [evg_pkg::SCALE_W-1:0]   scale_i,
  output logic [evg_pkg::VAR_W-1:0]     variate_o
);
  import evg_pkg::*;

  logic [X_W-1:0]     x_q, x_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [SUM_W-1:0]   log_sum_q, log_sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [VAR_W-1:0]   variate_q;

  logic [X_W:0]       x_ext, x_step;
  logic [TAB_IDX_W-1:0] tab_sel;
  logic [TERM_W-1:0]  term;
  logic [SUM_W:0]     sum_raw;
  logic [SUM_W-1:0]   sum_sat;
  logic [SHAPE_W-1:0] cnt_inc, shape_eff;
  logic [43:0]        mul_lo;
  logic [42:0]        mul_hi;

  // One shift-add step: x + x >> i, taken while it stays at or below one
  assign tab_sel = {1'b0, cmd_i.idx} + TAB_IDX_W'(1);
  assign x_ext   = {1'b0, x_q};
  assign x_step  = x_ext + (x_ext >> tab_sel);

  // Rounded -ln(u) in Q.27: rounding constant preloaded into the accumulator
  assign term    = acc_q[ACC_W-1 -: TERM_W];
  assign sum_raw = {1'b0, log_sum_q} + (SUM_W + 1)'(term);
  assign sum_sat = sum_raw[SUM_W] ? '1 : sum_raw[SUM_W-1:0];

  // Effective shape: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    priority if (shape_i == '0) begin
      shape_eff = SHAPE_W'(1);
    end else if (shape_i > SHAPE_W'(MAX_SHAPE)) begin
      shape_eff = SHAPE_W'(MAX_SHAPE);
    end else begin
      shape_eff = shape_i;
    end
  end

  assign cnt_inc = {1'b0, cnt_q} + SHAPE_W'(1);

  assign sts_o.word_zero = (word_i == '0);
  assign sts_o.emit      = (cnt_inc >= shape_eff);

  // Scale multiply in two halves of the sum
  assign mul_lo = log_sum_q[MUL_SPLIT-1:0] * scale_i;
  assign mul_hi = log_sum_q[SUM_W-1:MUL_SPLIT] * scale_i;

  // Next-value logic
  always_comb begin
    x_d       = x_q;
    acc_d     = acc_q;
    log_sum_d = log_sum_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    if (cmd_i.load) begin
      x_d   = {1'b0, word_i, 26'b0};
      acc_d = ROUND_Q;
    end
    if (cmd_i.norm) begin
      unique case (cmd_i.idx)
        STEP_W'(0): if (x_q[57:42] == '0) begin
          x_d   = x_q << 16;
          acc_d = acc_q + LN2_X16_Q;
        end
        STEP_W'(1): if (x_q[57:50] == '0) begin
          x_d   = x_q << 8;
          acc_d = acc_q + LN2_X8_Q;
        end
        STEP_W'(2): if (x_q[57:54] == '0) begin
          x_d   = x_q << 4;
          acc_d = acc_q + LN2_X4_Q;
        end
        STEP_W'(3): if (x_q[57:56] == '0) begin
          x_d   = x_q << 2;
          acc_d = acc_q + LN2_X2_Q;
        end
        default: if (!x_q[57]) begin
          x_d   = x_q << 1;
          acc_d = acc_q + LN2_Q;
        end
      endcase
    end
    if (cmd_i.iter) begin
      if (x_step <= (X_W + 1)'(ONE_Q)) begin
        x_d   = x_step[X_W-1:0];
        acc_d = acc_q + ACC_W'(STEP_LOG[tab_sel]);
      end
    end
    if (cmd_i.fin) begin
      acc_d = acc_q + ONE_Q - ACC_W'(x_q);
    end
    if (cmd_i.sum) begin
      log_sum_d = sum_sat;
      cnt_d     = sts_o.emit ? '0 : cnt_inc[CNT_W-1:0];
    end
    if (cmd_i.mul_lo) begin
      prod_d = PROD_W'(mul_lo);
    end
    if (cmd_i.mul_hi) begin
      prod_d    = prod_q + {mul_hi, {MUL_SPLIT{1'b0}}};
      log_sum_d = '0;
    end
  end

  // Running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_sum_q <= '0;
      cnt_q     <= '0;
    end else begin
      log_sum_q <= log_sum_d;
      cnt_q     <= cnt_d;
    end
  end

  // Working and output registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    if (cmd_i.out_load) begin
      variate_q <= prod_q[PROD_W-1 -: VAR_W];
    end
  end

  assign variate_o = variate_q;

endmodule

@@ rtl/evg_ctrl.sv @@
// Controller: sequences normalise, logarithm, sum and multiply steps for each word.
module evg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  evg_pkg::evg_sts_t sts_i,
  output evg_pkg::evg_cmd_t cmd_o
);
  import evg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_ITER, ST_FIN, ST_SUM, ST_MUL_LO, ST_MUL_HI, ST_OUT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic              out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.idx      = step_q;
    cmd_o.load     = in_ready_o && in_valid_i && !sts_i.word_zero;
    cmd_o.norm     = (state_q == ST_NORM);
    cmd_o.iter     = (state_q == ST_ITER);
    cmd_o.fin      = (state_q == ST_FIN);
    cmd_o.sum      = (state_q == ST_SUM);
    cmd_o.mul_lo   = (state_q == ST_MUL_LO);
    cmd_o.mul_hi   = (state_q == ST_MUL_HI);
    cmd_o.out_load = (state_q == ST_OUT) && out_free;
  end

  // State, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Output valid: set on load, cleared when the word is taken
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (cmd_o.load) begin
          state_q <= ST_NORM;
          step_q  <= '0;
        end
        ST_NORM: begin
          if (step_q == STEP_W'(NORM_LAST)) begin
            state_q <= ST_ITER;
            step_q  <= '0;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_ITER: begin
          if (step_q == STEP_W'(LOG_STEPS - 1)) begin
            state_q <= ST_FIN;
          end
          step_q <= step_q + STEP_W'(1);
        end
        ST_FIN:    state_q <= ST_SUM;
        ST_SUM:    state_q <= sts_i.emit ? ST_MUL_LO : ST_IDLE;
        ST_MUL_LO: state_q <= ST_MUL_HI;
        ST_MUL_HI: state_q <= ST_OUT;
        ST_OUT: if (out_free) begin
          state_q <= ST_IDLE;
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  // A pending result word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten while still pending");

  // The multiply state follows a sum step that reaches the shape
  a_emit_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.sum && sts_i.emit) |=> (state_q == ST_MUL_LO))
    else $error("variate not emitted after final word");

  // Upper partial product always follows the lower one
  a_mul_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_hi |-> $past(cmd_o.mul_lo))
    else $error("upper partial product without lower one");

  // Output valid rises only after the output register was loaded
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.out_load))
    else $error("output valid without a loaded word");

endmodule

@@ bench/tb.sv @@
// Testbench for the Erlang variate generator core: directed table, random words, self-checking.
module tb;
  import evg_pkg::*;

  localparam int unsigned WORDS_PER_PHASE = 98;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned SETTLE_CYCLES   = 48;
  localparam logic [63:0] Q58_ONE         = 64'd1 << 58;
  localparam logic [63:0] SUM_LIMIT       = (64'd1 << SUM_W) - 64'd1;

  typedef enum logic [1:0] {ROW_WORD, ROW_SHAPE, ROW_SCALE} row_op_e;

  typedef struct packed {
    row_op_e           op;
    logic [WORD_W-1:0] value;
    logic              typed;
    logic [VAR_W-1:0]  want;
  } stim_row_t;

  // Directed rows: extremes, zero words, scale and shape corner cases
  stim_row_t stim_plan [27] = '{
    '{ROW_WORD,  32'h8000_0000, 1'b1, 36'd45426},
    '{ROW_WORD,  32'h0000_0001, 1'b1, 36'd1453634},
    '{ROW_WORD,  32'hFFFF_FFFF, 1'b1, 36'd0},
    '{ROW_WORD,  32'h0000_0000, 1'b0, 36'd0},
    '{ROW_WORD,  32'h7FFF_FFFF, 1'b0, 36'd0},
    '{ROW_WORD,  32'hAAAA_AAAA, 1'b0, 36'd0},
    '{ROW_WORD,  32'h5555_5555, 1'b0, 36'd0},
    '{ROW_SCALE, 32'h00FF_FFFF, 1'b0, 36'd0},
    '{ROW_WORD,  32'h0000_0001, 1'b0, 36'd0},
    '{ROW_SCALE, 32'h0000_0000, 1'b0, 36'd0},
    '{ROW_WORD,  32'h1234_5678, 1'b1, 36'd0},
    '{ROW_SCALE, 32'h0000_0001, 1'b0, 36'd0},
    '{ROW_WORD,  32'h0000_0001, 1'b1, 36'd22},
    '{ROW_SHAPE, 32'h0000_0000, 1'b0, 36'd0},
    '{ROW_SCALE, 32'h0001_0000, 1'b0, 36'd0},
    '{ROW_WORD,  32'h8000_0000, 1'b1, 36'd45426},
    '{ROW_SHAPE, 32'h0000_0003, 1'b0, 36'd0},
    '{ROW_WORD,  32'h0000_0002, 1'b0, 36'd0},
    '{ROW_WORD,  32'h0000_0000, 1'b0, 36'd0},
    '{ROW_WORD,  32'hC000_0000, 1'b0, 36'd0},
    '{ROW_WORD,  32'h0000_FFFF, 1'b0, 36'd0},
    '{ROW_WORD,  32'h0080_0000, 1'b0, 36'd0},
    '{ROW_WORD,  32'h4000_0000, 1'b0, 36'd0},
    '{ROW_SHAPE, 32'h0000_0001, 1'b0, 36'd0},
    '{ROW_WORD,  32'h2000_0000, 1'b0, 36'd0},
    '{ROW_SHAPE, 32'h0000_007F, 1'b0, 36'd0},
    '{ROW_WORD,  32'hFFFF_0000, 1'b0, 36'd0}
  };

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  evg_in_if  word_ch ();
  evg_out_if variate_ch ();

  erlang_variate_generator_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (word_ch),
    .out_o   (variate_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: register mirror, running count and log sum
  logic [63:0]        ln_step_q58 [1:LOG_STEPS];
  logic [63:0]        ln2_q58;
  logic [SHAPE_W-1:0] shape_mirror;
  logic [SCALE_W-1:0] scale_mirror;
  int unsigned        words_in_variate;
  logic [SUM_W-1:0]   log_acc;

  logic [VAR_W-1:0] variates_due [$];
  int unsigned mismatches;
  int unsigned words_taken;
  int unsigned zero_words;
  int unsigned variates_seen;
  int unsigned settings_used;

  int unsigned stall_left;
  int unsigned tick;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ln 2 and ln(1 + 2^-i) in Q.58 from truncated series
  function automatic void build_log_tables();
    logic [63:0] acc;
    ln2_q58 = '0;
    for (int n = 1; n <= 58; n++) begin
      ln2_q58 = ln2_q58 + (Q58_ONE >> n) / 64'(n);
    end
    for (int i = 1; i <= LOG_STEPS; i++) begin
      acc = '0;
      for (int n = 1; n * i <= 58; n++) begin
        if (n % 2 == 1) begin
          acc = acc + (Q58_ONE >> (n * i)) / 64'(n);
        end else begin
          acc = acc - (Q58_ONE >> (n * i)) / 64'(n);
        end
      end
      ln_step_q58[i] = acc;
    end
  endfunction

  // -ln(w / 2^32) in Q.27, rounded; w is nonzero
  function automatic logic [63:0] neg_ln_q27(input logic [WORD_W-1:0] w);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] acc;
    int          lead;
    lead = 31;
    while (lead > 0 && !w[lead]) lead--;
    x   = ({32'b0, w} << (31 - lead)) << 26;
    acc = '0;
    for (int i = 1; i <= LOG_STEPS; i++) begin
      t = x + (x >> i);
      if (t <= Q58_ONE) begin
        x   = t;
        acc = acc + ln_step_q58[i];
      end
    end
    acc = acc + (Q58_ONE - x);
    acc = acc + 64'(31 - lead) * ln2_q58;
    return (acc + (64'd1 << 30)) >> 31;
  endfunction

  // Fold one word into the sum; returns 1 with the variate when one is due
  function automatic bit accumulate_word(input logic [WORD_W-1:0] w,
                                         output logic [VAR_W-1:0] variate);
    int unsigned k;
    logic [63:0] sum;
    logic [63:0] prod;
    variate = '0;
    if (w == '0) return 1'b0;
    k = 32'(shape_mirror);
    if (k == 0) k = 1;
    if (k > MAX_SHAPE) k = MAX_SHAPE;
    sum = 64'(log_acc) + neg_ln_q27(w);
    if (sum > SUM_LIMIT) sum = SUM_LIMIT;
    words_in_variate++;
    if (words_in_variate >= k) begin
      prod    = sum * 64'(scale_mirror);
      variate = VAR_W'(prod >> SUM_FRAC);
      log_acc = '0;
      words_in_variate = 0;
      return 1'b1;
    end
    log_acc = SUM_W'(sum);
    return 1'b0;
  endfunction

  // APB write, then read back and compare
  task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] held;
    held = (idx == REG_SHAPE) ? PDATA_W'(data[SHAPE_W-1:0]) : PDATA_W'(data[SCALE_W-1:0]);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_SHAPE) shape_mirror = data[SHAPE_W-1:0];
    else scale_mirror = data[SCALE_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== held) begin
      $display("%0t: register %0d read back, expected %0d, got %0d", $time, idx, held, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // Offer one word and hold it until taken; log the expected variate
  task automatic send_word(input logic [WORD_W-1:0] w, input logic typed,
                           input logic [VAR_W-1:0] want);
    logic [VAR_W-1:0] v;
    @(negedge clk);
    word_ch.valid        <= 1'b1;
    word_ch.uniform_word <= w;
    do @(posedge clk); while (!word_ch.ready);
    words_taken++;
    if (w == '0) zero_words++;
    if (accumulate_word(w, v)) variates_due.push_back(typed ? want : v);
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      word_ch.valid        <= 1'b0;
      word_ch.uniform_word <= $urandom;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Sender stops until every due variate is out and the core has settled
  task automatic drain();
    @(negedge clk);
    word_ch.valid <= 1'b0;
    while (variates_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random word: mostly full range, some small, near one, or zero
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2:       return WORD_W'($urandom_range(1, 16));
      3, 4:    return $urandom >> $urandom_range(1, 31);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, with calm stretches where it never stalls
  always @(negedge clk) begin
    tick++;
    if (stall_left != 0) begin
      variate_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      variate_ch.ready <= 1'b1;
      if ((tick % 3000) >= 800 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 60);
    end
  end

  // Compare every delivered variate against the oldest one due
  always @(posedge clk) begin
    if (rst_n && variate_ch.valid && variate_ch.ready) begin
      variates_seen++;
      if (variates_due.size() == 0) begin
        $display("%0t: variate with none due, got %0d", $time, variate_ch.variate_value);
        mismatches++;
      end else if (variate_ch.variate_value !== variates_due[0]) begin
        $display("%0t: variate mismatch, expected %0d, got %0d", $time, variates_due[0],
                 variate_ch.variate_value);
        mismatches++;
        void'(variates_due.pop_front());
      end else begin
        void'(variates_due.pop_front());
      end
    end
  end

  // Watchdog
  initial begin
    #(64'd20_000_000);
    $display("erlang_variate_generator_core verification failed");
    $finish;
  end

  initial begin
    logic [WORD_W-1:0]  w;
    logic [SHAPE_W-1:0] shape;
    logic [SCALE_W-1:0] scale;
    int unsigned        taken;
    int unsigned        burst_left;
    int unsigned        gap;
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    word_ch.valid        = 1'b0;
    word_ch.uniform_word = '0;
    variate_ch.ready     = 1'b0;
    stall_left           = 0;
    tick                 = 0;
    mismatches           = 0;
    words_taken          = 0;
    zero_words           = 0;
    variates_seen        = 0;
    settings_used        = 0;
    build_log_tables();
    shape_mirror     = SHAPE_W'(1);
    scale_mirror     = SCALE_W'(65536);
    words_in_variate = 0;
    log_acc          = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    foreach (stim_plan[r]) begin
      case (stim_plan[r].op)
        ROW_WORD: begin
          send_word(stim_plan[r].value, stim_plan[r].typed, stim_plan[r].want);
        end
        ROW_SHAPE: begin
          drain();
          reg_write(REG_SHAPE, stim_plan[r].value);
        end
        default: begin
          drain();
          reg_write(REG_SCALE, stim_plan[r].value);
        end
      endcase
    end

    // Random part: one register setting per phase, extremes first
    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin shape = 7'd1;   scale = 24'hFF_FFFF;        end
        1: begin shape = 7'd64;  scale = 24'd1;              end
        2: begin shape = 7'd127; scale = SCALE_W'($urandom); end
        3: begin shape = 7'd0;   scale = 24'd0;              end
        4: begin shape = 7'd2;   scale = 24'd65536;          end
        default: begin
          shape = ($urandom_range(0, 4) == 0) ? SHAPE_W'($urandom_range(0, 127))
                                              : SHAPE_W'($urandom_range(1, 8));
          scale = SCALE_W'($urandom);
        end
      endcase
      drain();
      reg_write(REG_SHAPE, PDATA_W'(shape));
      reg_write(REG_SCALE, PDATA_W'(scale));
      taken = 0;
      while (taken < WORDS_PER_PHASE) begin
        w = pick_word();
        send_word(w, 1'b0, '0);
        if (w != '0) taken++;
        if (burst_left == 0) begin
          case ($urandom_range(0, 3))
            0:       gap = 0;
            1, 2:    gap = $urandom_range(1, 8);
            default: gap = $urandom_range(9, 50);
          endcase
          idle_cycles(gap);
          burst_left = $urandom_range(1, 20);
        end else begin
          burst_left--;
        end
      end
    end

    // Let the last variates out, then a settling margin
    drain();
    $display("Took %0d uniform words (%0d zero) and checked %0d variates", words_taken,
             zero_words, variates_seen);
    $display("across %0d register writes, shapes 0 to 127 and scales 0 to full range",
             settings_used);
    if (mismatches == 0) begin
      $display("erlang_variate_generator_core verification clean");
    end else begin
      $display("erlang_variate_generator_core verification failed");
    end
    $finish;
  end

endmodule
